// File: hdl/strg_pkg.sv
// Shared constants and controller/datapath interface types for the slope threshold run gate.
package strg_pkg;

   localparam int COORD_W    = 32;
   localparam int ELEV_W     = 32;
   localparam int GAIN_W     = 32;
   localparam int RATIO_W    = 32;
   localparam int MIN_RUN_W  = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 2 * COORD_W + ELEV_W + GAIN_W;
   localparam int RSP_DATA_W = 2 * COORD_W + RATIO_W;
   localparam int PROD_W     = ELEV_W + 1 + GAIN_W;
   localparam int FRAC_SHIFT = 24;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_RUN   = 1'd1;

   typedef struct packed {
      logic load;
      logic mult;
      logic buf_write;
      logic run_clear;
      logic set_passing;
      logic flush_start;
      logic emit_pass;
      logic flush_emit;
   } dp_cmd_type;

   typedef struct packed {
      logic had_prev;
      logic flagged;
      logic passing;
      logic reach;
      logic flush_last;
      logic eol;
      logic out_free;
   } dp_sts_type;

endpackage

// File: hdl/strg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module strg_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// File: hdl/strg_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module strg_ctrl
   import strg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_DECIDE,
      S_EMIT,
      S_FRD,
      S_FWAIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.mult = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (!sts.had_prev || !sts.flagged) begin
               cmd.run_clear = 1'b1;
               state_in      = S_IDLE;
            end else if (sts.passing) begin
               state_in = S_EMIT;
            end else begin
               cmd.buf_write = 1'b1;
               if (sts.reach) begin
                  cmd.flush_start = 1'b1;
                  state_in        = S_FRD;
               end else begin
                  cmd.run_clear = sts.eol;
                  state_in      = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_pass = 1'b1;
               cmd.run_clear = sts.eol;
               state_in      = S_IDLE;
            end
         end
         S_FRD: begin
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (sts.out_free) begin
               cmd.flush_emit = 1'b1;
               if (sts.flush_last) begin
                  cmd.run_clear   = sts.eol;
                  cmd.set_passing = !sts.eol;
                  state_in        = S_IDLE;
               end else begin
                  state_in = S_FRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_pass || cmd.flush_emit) |-> sts.out_free)
      else $error("result loaded while the output register is occupied");

   a_single_emit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_pass && cmd.flush_emit))
      else $error("pass-through and flush results loaded together");

   a_no_buffer_when_passing: assert property (@(posedge clock) disable iff (reset)
      cmd.buf_write |-> !sts.passing)
      else $error("point buffered while the run is already passing");
`endif

endmodule

// File: hdl/strg_dp.sv
// Datapath: ratio computation, run buffer, run counters and output register.
module strg_dp
   import strg_pkg::*;
#(
   parameter int MAX_RUN = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int CW = $clog2(MAX_RUN + 1);
   localparam int AW = $clog2(MAX_RUN > 1 ? MAX_RUN : 2);
   localparam int NW = (CW > MIN_RUN_W) ? CW : MIN_RUN_W;

   logic [RATIO_W-1:0]   threshold_ff;
   logic [MIN_RUN_W-1:0] min_run_ff;

   logic [ELEV_W-1:0]  prev_elev_ff;
   logic [COORD_W-1:0] prev_x_ff;
   logic [COORD_W-1:0] prev_y_ff;
   logic               have_prev_ff;

   logic [COORD_W-1:0] pt_x_ff;
   logic [COORD_W-1:0] pt_y_ff;
   logic [ELEV_W:0]    adiff_ff;
   logic [GAIN_W-1:0]  again_ff;
   logic               had_prev_ff;
   logic               eol_ff;
   logic [PROD_W-1:0]  prod_ff;

   logic [CW-1:0] count_ff, count_in;
   logic          passing_ff, passing_in;
   logic [CW-1:0] idx_ff, idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [COORD_W-1:0] in_x;
   logic [COORD_W-1:0] in_y;
   logic [ELEV_W-1:0]  in_elev;
   logic [GAIN_W-1:0]  in_gain;
   logic [ELEV_W:0]    diff;
   logic [ELEV_W:0]    adiff;
   logic [GAIN_W-1:0]  again;
   logic [PROD_W-1:0]  prod_in;
   logic [RATIO_W-1:0] ratio;
   logic               flagged;
   logic [CW-1:0]      count_inc;
   logic [NW-1:0]      min_ext;
   logic [NW-1:0]      need;
   logic               has_room;
   logic               flush_last;
   logic [RSP_DATA_W-1:0] point_word;
   logic [RSP_DATA_W-1:0] ram_rdata;

   assign in_x    = req_tdata[COORD_W-1:0];
   assign in_y    = req_tdata[2*COORD_W-1:COORD_W];
   assign in_elev = req_tdata[2*COORD_W+ELEV_W-1:2*COORD_W];
   assign in_gain = req_tdata[REQ_DATA_W-1:2*COORD_W+ELEV_W];

   assign diff  = {in_elev[ELEV_W-1], in_elev} - {prev_elev_ff[ELEV_W-1], prev_elev_ff};
   assign adiff = diff[ELEV_W] ? (~diff + 1'b1) : diff;
   assign again = in_gain[GAIN_W-1] ? (~in_gain + 1'b1) : in_gain;

   assign prod_in = PROD_W'(adiff_ff) * PROD_W'(again_ff);
   assign ratio   = (|prod_ff[PROD_W-1:FRAC_SHIFT+RATIO_W]) ? '1
                  : prod_ff[FRAC_SHIFT+RATIO_W-1:FRAC_SHIFT];
   assign flagged = ratio > threshold_ff;

   assign has_room  = count_ff < CW'(MAX_RUN);
   assign count_inc = has_room ? CW'(count_ff + 1'b1) : count_ff;
   assign min_ext   = NW'(min_run_ff);
   assign need      = (min_ext == '0) ? NW'(1)
                    : ((min_ext > NW'(MAX_RUN)) ? NW'(MAX_RUN) : min_ext);
   assign flush_last = (CW'(idx_ff + 1'b1) == count_ff);
   assign point_word = {ratio, pt_y_ff, pt_x_ff};

   strg_ram #(
      .WIDTH (RSP_DATA_W),
      .DEPTH (MAX_RUN)
   ) u_run_buf (
      .clock      (clock),
      .wr_en      (cmd.buf_write && has_room),
      .wr_addr    (count_ff[AW-1:0]),
      .wr_data    (point_word),
      .rd_addr    (idx_ff[AW-1:0]),
      .rd_data_ff (ram_rdata)
   );

   always_comb begin
      sts.had_prev   = had_prev_ff;
      sts.flagged    = flagged;
      sts.passing    = passing_ff;
      sts.reach      = NW'(count_inc) >= need;
      sts.flush_last = flush_last;
      sts.eol        = eol_ff;
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.run_clear) begin
         count_in = '0;
      end else if (cmd.buf_write) begin
         count_in = count_inc;
      end

      passing_in = passing_ff;
      if (cmd.run_clear) begin
         passing_in = 1'b0;
      end else if (cmd.set_passing) begin
         passing_in = 1'b1;
      end

      idx_in = idx_ff;
      if (cmd.flush_start) begin
         idx_in = '0;
      end else if (cmd.flush_emit) begin
         idx_in = CW'(idx_ff + 1'b1);
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit_pass) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = point_word;
         rsp_last_in  = 1'b1;
      end else if (cmd.flush_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = ram_rdata;
         rsp_last_in  = flush_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         min_run_ff   <= MIN_RUN_W'(1);
         have_prev_ff <= 1'b0;
         count_ff     <= '0;
         passing_ff   <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_THRESHOLD: threshold_ff <= csr_wdata[RATIO_W-1:0];
               REG_MIN_RUN:   min_run_ff   <= csr_wdata[MIN_RUN_W-1:0];
               default:       ;
            endcase
         end
         if (cmd.load) begin
            have_prev_ff <= !req_tlast;
         end
         count_ff     <= count_in;
         passing_ff   <= passing_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prev_elev_ff <= in_elev;
         prev_x_ff    <= in_x;
         prev_y_ff    <= in_y;
         pt_x_ff      <= prev_x_ff;
         pt_y_ff      <= prev_y_ff;
         adiff_ff     <= adiff;
         again_ff     <= again;
         had_prev_ff  <= have_prev_ff;
         eol_ff       <= req_tlast;
      end
      if (cmd.mult) begin
         prod_ff <= prod_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RUN))
      else $error("run count exceeds buffer depth");

   a_flush_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_emit |-> (idx_ff < count_ff))
      else $error("flush reads past the buffered run");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed before it was taken");
`endif

endmodule

// File: hdl/slope_threshold_run_gate_top.sv
// Top level of the slope threshold run gate: controller, datapath and configuration port.
//
// Channel  Direction  Handshake          Payload
// req_     in         tvalid/tready      tdata {gain, elevation, y, x}, tlast end of line
// rsp_     out        tvalid/tready      tdata {ratio, y, x}, tlast last result of the request
// csr_     in         we (no wait)       index, wdata
//
// A request that yields no result passes the calc and decide states; when a passing run
// forwards its point it also passes the emit state, which waits for a free output register.
// When a run reaches its minimum length the buffered points are flushed from the run memory
// one at a time via its registered read port; no request is accepted until the flush ends.
// Reset is synchronous and active high; the run memory is not cleared.
// A stalled result stays in the output register, and the next request is accepted meanwhile.
module slope_threshold_run_gate_top
   import strg_pkg::*;
#(
   parameter int MAX_RUN = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample_x, sample_y, elevation, gain
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // point_x, point_y, ratio
   output logic                  rsp_tlast
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   strg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   strg_dp #(
      .MAX_RUN (MAX_RUN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: bench/tb_slope_threshold_run_gate_top.sv
// Self-checking testbench for the slope threshold run gate: directed table and random lines.
`timescale 1ns / 1ps

module tb_slope_threshold_run_gate_top;
   import strg_pkg::*;

   localparam int          RUN_DEPTH    = 64;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_ITEMS = 300;
   localparam logic [31:0] GAIN_ONE     = 32'h0100_0000;
   localparam logic [31:0] GAIN_NEG_ONE = 32'hFF00_0000;
   localparam logic [31:0] Q16_ONE      = 32'h0001_0000;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] ratio;
      logic        last;
   } point_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_chk_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [31:0]           csr_val;
      logic [31:0]           x;
      logic [31:0]           y;
      logic [31:0]           elev;
      logic [31:0]           gain;
      logic                  eol;
      row_chk_type           chk;
      logic [31:0]           ratio;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // sample_x, sample_y, elevation, gain
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // point_x, point_y, ratio
   logic                  rsp_tlast;

   slope_threshold_run_gate_top #(
      .MAX_RUN (RUN_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Configuration and run state mirrored from the block.
   logic [31:0] threshold_cfg;
   logic [6:0]  min_run_cfg;
   logic [31:0] prior_elev;
   logic [31:0] prior_x;
   logic [31:0] prior_y;
   logic        have_prior;
   logic        passing;
   int          run_len;
   logic [31:0] run_x     [RUN_DEPTH];
   logic [31:0] run_y     [RUN_DEPTH];
   logic [31:0] run_ratio [RUN_DEPTH];

   point_type new_points[$];
   point_type pending_points[$];

   int errors;
   int points_checked;
   int samples_sent;
   int streak_left;

   dir_row_type dir_rows [25] = '{
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd1, 32'd2, 32'h0, GAIN_ONE, 1'b0, CHK_NONE, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd3, 32'd4, Q16_ONE, GAIN_ONE, 1'b0, CHK_ONE, Q16_ONE},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd5, 32'd6, Q16_ONE, GAIN_ONE, 1'b0, CHK_NONE, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd7, 32'd8, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0,
        CHK_ONE, 32'hFFFF_FFFF},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd9, 32'd10, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
        CHK_ONE, 32'hFFFF_FFFF},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1,
        CHK_NONE, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 32'h0, 1'b0,
        CHK_NONE, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd11, 32'd12, 32'd9, 32'h0, 1'b0, CHK_NONE, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd13, 32'd14, 32'h0100_0009, 32'hFFFF_FFFF, 1'b0,
        CHK_ONE, 32'd1},
      '{ROW_CSR, REG_THRESHOLD, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, CHK_NONE, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd15, 32'd16, 32'h8000_0000, 32'h8000_0000, 1'b0,
        CHK_NONE, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd17, 32'd18, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
        CHK_NONE, 32'd0},
      '{ROW_CSR, REG_THRESHOLD, Q16_ONE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, CHK_NONE, 32'd0},
      '{ROW_CSR, REG_MIN_RUN, 32'd3, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, CHK_NONE, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd20, 32'd21, 32'h0, GAIN_ONE, 1'b0, CHK_MODEL, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd22, 32'd23, 32'h2_0000, GAIN_ONE, 1'b0,
        CHK_MODEL, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd24, 32'd25, 32'h4_0000, GAIN_NEG_ONE, 1'b0,
        CHK_MODEL, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd26, 32'd27, 32'h6_0000, GAIN_ONE, 1'b0,
        CHK_MODEL, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd28, 32'd29, 32'h8_0000, GAIN_ONE, 1'b0,
        CHK_MODEL, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd30, 32'd31, 32'h8_0000, GAIN_ONE, 1'b0,
        CHK_MODEL, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd32, 32'd33, 32'hA_0000, GAIN_ONE, 1'b0,
        CHK_MODEL, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd34, 32'd35, 32'hC_0000, GAIN_ONE, 1'b1,
        CHK_MODEL, 32'd0},
      '{ROW_CSR, REG_MIN_RUN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, CHK_NONE, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd36, 32'd37, 32'h0, GAIN_ONE, 1'b0, CHK_NONE, 32'd0},
      '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 32'd38, 32'd39, 32'hFFFE_0000, GAIN_NEG_ONE, 1'b1,
        CHK_ONE, 32'h2_0000}
   };

   function automatic logic [31:0] slope_ratio(input logic [31:0] e_now,
                                              input logic [31:0] e_prev,
                                              input logic [31:0] g);
      logic signed [32:0] d;
      logic [32:0]        ad;
      logic [31:0]        ag;
      logic [64:0]        p;
      d  = $signed({e_now[31], e_now}) - $signed({e_prev[31], e_prev});
      ad = d[32] ? -d : d;
      ag = g[31] ? -g : g;
      p  = (ad * ag) >> FRAC_SHIFT;
      return (p > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
   endfunction

   task automatic gate_sample(input logic [31:0] sx, input logic [31:0] sy,
                              input logic [31:0] el, input logic [31:0] g, input logic eol);
      logic [31:0] r;
      int          need;
      point_type   pt;
      new_points.delete();
      if (have_prior) begin
         r = slope_ratio(el, prior_elev, g);
         if (r > threshold_cfg) begin
            need = (min_run_cfg < 1) ? 1 : (min_run_cfg > RUN_DEPTH) ? RUN_DEPTH : min_run_cfg;
            if (passing) begin
               pt = '{prior_x, prior_y, r, 1'b0};
               new_points.insert(new_points.size(), pt);
            end else begin
               if (run_len < RUN_DEPTH) begin
                  run_x[run_len]     = prior_x;
                  run_y[run_len]     = prior_y;
                  run_ratio[run_len] = r;
                  run_len++;
               end
               if (run_len >= need) begin
                  for (int i = 0; i < run_len; i++) begin
                     pt = '{run_x[i], run_y[i], run_ratio[i], 1'b0};
                     new_points.insert(new_points.size(), pt);
                  end
                  passing = 1'b1;
               end
            end
         end else begin
            run_len = 0;
            passing = 1'b0;
         end
      end else begin
         run_len = 0;
         passing = 1'b0;
      end
      prior_elev = el;
      prior_x    = sx;
      prior_y    = sy;
      have_prior = !eol;
      if (eol) begin
         run_len = 0;
         passing = 1'b0;
      end
      if (new_points.size() > 0)
         new_points[new_points.size() - 1].last = 1'b1;
   endtask

   task automatic issue_sample(input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] el, input logic [31:0] g, input logic eol,
                               input row_chk_type chk, input logic [31:0] typed_ratio);
      point_type typed;
      int        gap;
      typed = '{prior_x, prior_y, typed_ratio, 1'b1};
      req_tvalid <= 1'b1;
      req_tdata  <= {g, el, sy, sx};
      req_tlast  <= eol;
      do @(posedge clock); while (!req_tready);
      gate_sample(sx, sy, el, g, eol);
      case (chk)
         CHK_MODEL: begin
            foreach (new_points[i]) pending_points.insert(pending_points.size(), new_points[i]);
         end
         CHK_ONE: begin
            pending_points.insert(pending_points.size(), typed);
         end
         default: ;
      endcase
      samples_sent++;
      if (streak_left > 0) begin
         streak_left--;
      end else begin
         streak_left = $urandom_range(0, 24);
         gap         = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == REG_THRESHOLD)
         threshold_cfg = val;
      else
         min_run_cfg = val[6:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : timeout
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Run stopped after %0d cycles with %0d results still outstanding.",
               CYCLE_LIMIT, pending_points.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : receiver
      int mode;
      int span;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(1, 30);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'b0;
               2: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      point_type got;
      point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tlast};
         if (pending_points.size() == 0) begin
            errors++;
            $display("%0t: unexpected result x=%h y=%h ratio=%h last=%b",
                     $realtime, got.x, got.y, got.ratio, got.last);
         end else begin
            want = pending_points.pop_front();
            points_checked++;
            if (got.x !== want.x || got.y !== want.y || got.ratio !== want.ratio ||
                got.last !== want.last) begin
               errors++;
               $display("%0t: mismatch, expected x=%h y=%h ratio=%h last=%b,",
                        $realtime, want.x, want.y, want.ratio, want.last);
               $display("%0t:           actual x=%h y=%h ratio=%h last=%b",
                        $realtime, got.x, got.y, got.ratio, got.last);
            end
         end
      end
   end

   initial begin : stimulus
      int          phase;
      int          phase_items;
      int          phase_quota;
      int          rand_items;
      int          line_len;
      int          flag_pct;
      int          noise_pct;
      int          pick;
      logic        long_run;
      logic [31:0] thr;
      logic [31:0] thr_s;
      logic [31:0] mr_word;
      logic [31:0] step;
      logic [31:0] el;
      logic [31:0] g;
      logic [31:0] elev_now;

      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = REG_THRESHOLD;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      errors         = 0;
      points_checked = 0;
      samples_sent   = 0;
      streak_left    = 0;
      threshold_cfg  = '0;
      min_run_cfg    = 7'd1;
      prior_elev     = '0;
      prior_x        = '0;
      prior_y        = '0;
      have_prior     = 1'b0;
      passing        = 1'b0;
      run_len        = 0;
      phase          = 0;
      rand_items     = 0;
      elev_now       = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain_results();
            csr_write(dir_rows[i].csr_idx, dir_rows[i].csr_val);
         end else begin
            issue_sample(dir_rows[i].x, dir_rows[i].y, dir_rows[i].elev, dir_rows[i].gain,
                         dir_rows[i].eol, dir_rows[i].chk, dir_rows[i].ratio);
         end
      end

      while (rand_items < RANDOM_ITEMS) begin
         phase++;
         long_run = (phase == 1 || phase == 2);
         pick     = $urandom_range(0, 9);
         if (long_run || pick > 2)
            thr = $urandom_range(1, 32'h4_0000);
         else if (pick == 0)
            thr = 32'd0;
         else if (pick == 1)
            thr = $urandom;
         else
            thr = 32'hFFFF_FFFF;
         case (phase)
            1: mr_word = 32'd64;
            2: mr_word = 32'hFFFF_FFFF;
            3: mr_word = $urandom & 32'hFFFF_FF80;
            default: mr_word = ($urandom & 32'hFFFF_FF80) | $urandom_range(1, 6);
         endcase
         thr_s       = (thr > 32'h4_0000) ? 32'h4_0000 : thr;
         flag_pct    = long_run ? 100 : $urandom_range(60, 95);
         noise_pct   = long_run ? 0 : 10;
         phase_quota = long_run ? 1 : 30;
         drain_results();
         csr_write(REG_THRESHOLD, thr);
         csr_write(REG_MIN_RUN, mr_word);
         phase_items = 0;
         while (phase_items < phase_quota) begin
            line_len = (phase == 1) ? 70 : (phase == 2) ? 67 : $urandom_range(1, 12);
            for (int k = 0; k < line_len; k++) begin
               if ($urandom_range(0, 99) < noise_pct) begin
                  el = $urandom;
                  g  = $urandom;
               end else begin
                  if ($urandom_range(0, 99) < flag_pct)
                     step = thr_s + 1 + $urandom_range(0, 32'h8000);
                  else
                     step = $urandom_range(0, thr_s);
                  el = (k == 0) ? $urandom :
                       ($urandom_range(0, 1) ? elev_now + step : elev_now - step);
                  g  = $urandom_range(0, 1) ? GAIN_ONE : GAIN_NEG_ONE;
               end
               elev_now = el;
               issue_sample($urandom, $urandom, el, g, k == line_len - 1, CHK_MODEL, 32'd0);
               rand_items++;
               phase_items++;
            end
         end
      end

      drain_results();
      $display("Sent %0d samples over %0d random configuration phases after the directed table.",
               samples_sent, phase);
      $display("Checked %0d flagged points, including full-length run flushes.", points_checked);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
